// ----- rtl/core/rce_pkg.sv -----
// ----------------------------------------------------------------------------
// rce_pkg
// Shared types, mode codes and helpers for the reward curve evaluator.
// ----------------------------------------------------------------------------
package rce_pkg;

    localparam int unsigned SHARE_W = 64;
    localparam int unsigned CURVE_W = 128;
    localparam int unsigned POS_W   = 7;

    typedef enum logic [1:0] {
        MODE_SQUARE = 2'd0,
        MODE_LINEAR = 2'd1,
        MODE_SQRT   = 2'd2,
        MODE_POW15  = 2'd3
    } curve_mode_t;

    // Leading-one position of a 128-bit value, halving search (7 levels).
    function automatic logic [POS_W-1:0] lead_pos(input logic [CURVE_W-1:0] v);
        logic [63:0]      t6;
        logic [31:0]      t5;
        logic [15:0]      t4;
        logic [7:0]       t3;
        logic [3:0]       t2;
        logic [1:0]       t1;
        logic [POS_W-1:0] p;
        p[6] = |v[127:64];
        t6   = p[6] ? v[127:64] : v[63:0];
        p[5] = |t6[63:32];
        t5   = p[5] ? t6[63:32] : t6[31:0];
        p[4] = |t5[31:16];
        t4   = p[4] ? t5[31:16] : t5[15:0];
        p[3] = |t4[15:8];
        t3   = p[3] ? t4[15:8] : t4[7:0];
        p[2] = |t3[7:4];
        t2   = p[2] ? t3[7:4] : t3[3:0];
        p[1] = |t2[3:2];
        t1   = p[1] ? t2[3:2] : t2[1:0];
        p[0] = t1[1];
        return p;
    endfunction

    // Approximate root for a nonzero value with leading one at p.
    function automatic logic [SHARE_W-1:0] root_combine(input logic [CURVE_W-1:0] v,
                                                        input logic [POS_W-1:0]   p);
        logic [CURVE_W-1:0] m;
        logic [CURVE_W-1:0] sh;
        logic [POS_W-1:0]   shamt;
        logic [SHARE_W-1:0] ebit;
        logic [SHARE_W-1:0] mh;
        logic [SHARE_W-1:0] mz;
        m     = v & ~(CURVE_W'(1) << p);
        shamt = p - {1'b0, p[POS_W-1:1]};
        sh    = m >> shamt;
        ebit  = SHARE_W'(1) << p[POS_W-1:1];
        mh    = p[0] ? ebit : '0;
        mz    = (mh | sh[SHARE_W-1:0]) >> 1;
        return ebit | mz;
    endfunction

endpackage

// ----- rtl/core/reward_curve_evaluator.sv -----
// ----------------------------------------------------------------------------
// reward_curve_evaluator
// Maps a 64-bit share count to a 128-bit curve value (square, identity,
// approximate square root or approximate power 1.5) in a 7-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   s_* : one share count per beat (s_tdata[63:0]).
//   m_* : one curve value per beat, m_tdata[63:0] = high word,
//         m_tdata[127:64] = low word.
//   cfg_* : curve_mode write (0 square, 1 linear, 2 root, 3 power 1.5);
//         always ready; the user must write only while the pipeline is empty (not checked).
// Throughput: one beat per cycle unless an output stall holds the pipeline.
//   Latency: 7 register stages, A to G; the result beat leaves from stage G. The
//   depth is the input capture stage plus the two multiplies (s*s, then sq*s
//   mod 2^128), each built from 32x32 partial products plus a summing stage,
//   followed by the leading-one search stage and the shift/merge stage.
// Stall: the whole pipeline holds while m_tvalid is high and m_tready low;
//   s_tready drops in that case. Stages move together, nothing is lost.
// Reset: valid bits clear, curve_mode returns to linear.
// ----------------------------------------------------------------------------
module reward_curve_evaluator (
    input  logic         aclk,
    input  logic         aresetn,
    // input: share_count
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,
    // output: curve_high [63:0], curve_low [127:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,
    // configuration: curve_mode
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_data
);
    import rce_pkg::*;

    // Global advance: every stage shifts when the output slot is free.
    logic adv;

    curve_mode_t mode_reg, mode_next;

    // Stage A: captured input
    logic               vld_a_reg;
    logic [SHARE_W-1:0] s_a_reg;
    curve_mode_t        mode_a_reg;

    // Stage B: partial products of s*s
    logic               vld_b_reg;
    logic [SHARE_W-1:0] s_b_reg;
    curve_mode_t        mode_b_reg;
    logic [63:0]        p00_b_reg, p01_b_reg, p11_b_reg;

    // Stage C: square, direct result
    logic               vld_c_reg;
    logic [SHARE_W-1:0] s_c_reg;
    curve_mode_t        mode_c_reg;
    logic [CURVE_W-1:0] sq_c_reg;
    logic [CURVE_W-1:0] dir_c_reg;
    logic [CURVE_W-1:0] sq_c_next;

    // Stage D: partial products of sq*s (mod 2^128)
    logic               vld_d_reg;
    logic [SHARE_W-1:0] s_d_reg;
    curve_mode_t        mode_d_reg;
    logic [CURVE_W-1:0] dir_d_reg;
    logic [63:0]        q00_d_reg, q01_d_reg, q10_d_reg, q11_d_reg, h00_d_reg;
    logic [31:0]        h01_d_reg, h10_d_reg;

    // Stage E: root operand
    logic               vld_e_reg;
    curve_mode_t        mode_e_reg;
    logic [CURVE_W-1:0] dir_e_reg;
    logic [CURVE_W-1:0] v_e_reg, v_e_next;

    // Stage F: leading-one position
    logic               vld_f_reg;
    curve_mode_t        mode_f_reg;
    logic [CURVE_W-1:0] dir_f_reg;
    logic [CURVE_W-1:0] v_f_reg;
    logic [POS_W-1:0]   pos_f_reg;
    logic               zero_f_reg;

    // Stage G: output register
    logic               vld_g_reg;
    curve_mode_t        mode_g_reg;
    logic [CURVE_W-1:0] res_g_reg, res_g_next;

    assign adv       = ~vld_g_reg | m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_g_reg;
    assign m_tdata   = {res_g_reg[63:0], res_g_reg[127:64]};

    assign mode_next = (cfg_valid && cfg_ready) ? curve_mode_t'(cfg_data) : mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_LINEAR;
        end else begin
            mode_reg <= mode_next;
        end
    end

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
            vld_e_reg <= 1'b0;
            vld_f_reg <= 1'b0;
            vld_g_reg <= 1'b0;
        end else if (adv) begin
            vld_a_reg <= s_tvalid;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            vld_d_reg <= vld_c_reg;
            vld_e_reg <= vld_d_reg;
            vld_f_reg <= vld_e_reg;
            vld_g_reg <= vld_f_reg;
        end
    end

    // Square: cross term counted twice
    assign sq_c_next = {p11_b_reg, 64'd0}
                     + {31'd0, p01_b_reg, 33'd0}
                     + {64'd0, p00_b_reg};

    // Cube mod 2^128: low word full product plus high word low product
    always_comb begin
        logic [CURVE_W-1:0] lo_prod;
        logic [63:0]        hi_prod;
        lo_prod = {q11_d_reg, 64'd0}
                + {32'd0, q01_d_reg, 32'd0}
                + {32'd0, q10_d_reg, 32'd0}
                + {64'd0, q00_d_reg};
        hi_prod = h00_d_reg + {h01_d_reg + h10_d_reg, 32'd0};
        if (mode_d_reg == MODE_POW15) begin
            v_e_next = lo_prod + {hi_prod, 64'd0};
        end else begin
            v_e_next = {64'd0, s_d_reg};
        end
    end

    always_comb begin
        if (mode_f_reg == MODE_SQRT || mode_f_reg == MODE_POW15) begin
            res_g_next = zero_f_reg ? '0 : {64'd0, root_combine(v_f_reg, pos_f_reg)};
        end else begin
            res_g_next = dir_f_reg;
        end
    end

    // Datapath, no reset
    always_ff @(posedge aclk) begin
        if (adv) begin
            // A
            s_a_reg    <= s_tdata;
            mode_a_reg <= mode_reg;
            // B
            s_b_reg    <= s_a_reg;
            mode_b_reg <= mode_a_reg;
            p00_b_reg  <= {32'd0, s_a_reg[31:0]}  * {32'd0, s_a_reg[31:0]};
            p01_b_reg  <= {32'd0, s_a_reg[31:0]}  * {32'd0, s_a_reg[63:32]};
            p11_b_reg  <= {32'd0, s_a_reg[63:32]} * {32'd0, s_a_reg[63:32]};
            // C
            s_c_reg    <= s_b_reg;
            mode_c_reg <= mode_b_reg;
            sq_c_reg   <= sq_c_next;
            dir_c_reg  <= (mode_b_reg == MODE_SQUARE) ? sq_c_next : {64'd0, s_b_reg};
            // D
            s_d_reg    <= s_c_reg;
            mode_d_reg <= mode_c_reg;
            dir_d_reg  <= dir_c_reg;
            q00_d_reg  <= {32'd0, sq_c_reg[31:0]}  * {32'd0, s_c_reg[31:0]};
            q01_d_reg  <= {32'd0, sq_c_reg[31:0]}  * {32'd0, s_c_reg[63:32]};
            q10_d_reg  <= {32'd0, sq_c_reg[63:32]} * {32'd0, s_c_reg[31:0]};
            q11_d_reg  <= {32'd0, sq_c_reg[63:32]} * {32'd0, s_c_reg[63:32]};
            h00_d_reg  <= {32'd0, sq_c_reg[95:64]} * {32'd0, s_c_reg[31:0]};
            h01_d_reg  <= sq_c_reg[95:64]  * s_c_reg[63:32];
            h10_d_reg  <= sq_c_reg[127:96] * s_c_reg[31:0];
            // E
            mode_e_reg <= mode_d_reg;
            dir_e_reg  <= dir_d_reg;
            v_e_reg    <= v_e_next;
            // F
            mode_f_reg <= mode_e_reg;
            dir_f_reg  <= dir_e_reg;
            v_f_reg    <= v_e_reg;
            pos_f_reg  <= lead_pos(v_e_reg);
            zero_f_reg <= ~|v_e_reg;
            // G
            mode_g_reg <= mode_f_reg;
            res_g_reg  <= res_g_next;
        end
    end

`ifndef NO_ASSERTIONS
    // Every input beat lands in stage A.
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_a_reg)
        else $error("accepted beat missing from stage A");

    // Only the square mode can produce a nonzero high word.
    a_high_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && mode_g_reg != MODE_SQUARE |-> m_tdata[63:0] == 64'd0)
        else $error("nonzero high word outside square mode");

    // A held output stalls the front of the pipeline.
    a_stall_front: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_a_reg && m_tvalid && !m_tready |=> vld_a_reg && $stable(s_a_reg))
        else $error("stage A lost its beat during a stall");
`endif

endmodule
